// File: rtl/core/dtq_pkg.sv
// dtq_pkg: shared constants, codes and slot types of the delayed-event timer queue
// used by every module under rtl/core; depends on nothing
package dtq_pkg;

  localparam int CAPACITY      = 8;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int TIME_W        = 16;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // input item modes
  localparam logic [1:0] MODE_SCHEDULE = 2'd0;
  localparam logic [1:0] MODE_TICK     = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  // configuration registers
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DELAY = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_STEP  = 1'd1;

  localparam logic [TIME_W-1:0] MAX_DELAY_RESET = 16'd5000;
  localparam logic [TIME_W-1:0] MAX_STEP_RESET  = 16'd100;

  typedef struct packed {
    logic [TIME_W-1:0]        rem;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } slot_wr_t;

endpackage

// File: rtl/core/delayed_event_timer_queue_core.sv
// delayed_event_timer_queue_core: top level of the delayed-event timer queue
// sequencer, config registers and output register; uses dtq_pkg, dtq_slot_store, dtq_sub_unit
//
//   channel   handshake                 payload
//   input     in_valid / in_ready       mode, delay_ms, event_payload, elapsed_ms
//   output    out_valid / out_ready     fired, fired_payload, last, pending_count, dropped_count
//   config    apb psel/penable/pwrite   paddr, pwdata, prdata, pready (always high)
//
// schedule, clear, no-op and a tick that starts no scan give a status result that is loaded
// into the output register at the transfer edge. a tick scan visits each slot through the
// shared subtract unit: memory read and evaluate per slot, plus a push state per expiring
// slot, and ends in a finish state that gives the last result.
// rst is synchronous active high; it empties the queue and restores register defaults.
// a stalled output holds the sequencer in its push or finish state, no slot is lost.
module delayed_event_timer_queue_core
  import dtq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // item input
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic [TIME_W-1:0]        delay_ms,
  input  logic [PAYLOAD_WIDTH-1:0] event_payload,
  input  logic [TIME_W-1:0]        elapsed_ms,
  // result output
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     fired,
  output logic [PAYLOAD_WIDTH-1:0] fired_payload,
  output logic                     last,
  output logic [CNT_W-1:0]         pending_count,
  output logic [15:0]              dropped_count,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_PUSH   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]               state;
  logic [CNT_W-1:0]         count;
  logic [15:0]              drop_cnt;
  logic [TIME_W-1:0]        max_delay;
  logic [TIME_W-1:0]        max_step;
  logic [TIME_W-1:0]        step;
  logic [IDX_W-1:0]         idx;
  // one expired event held back until we know whether it is the last
  logic                     have_buf;
  logic [PAYLOAD_WIDTH-1:0] buf_payload;
  logic [CNT_W-1:0]         buf_count;

  slot_t             rd_a;
  slot_t             rd_b;
  slot_wr_t          wr;
  logic [TIME_W-1:0] diff;
  logic              gt;

  logic                     out_free;
  logic                     in_xfer;
  logic                     full;
  logic [TIME_W-1:0]        delay_lim;
  logic [TIME_W-1:0]        delay_clamped;
  logic [TIME_W-1:0]        step_lim;
  logic [TIME_W-1:0]        step_clamped;
  logic [CNT_W-1:0]         last_slot;
  logic                     idx_more;
  logic                     push_go;
  logic                     cfg_wr;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     scan_start;
  logic                     load_out;

  // config port, pready tied high
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (reg_idx == REG_MAX_STEP) ? {16'd0, max_step} : {16'd0, max_delay};

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_xfer  = in_valid && in_ready;
  assign full     = count >= CNT_W'(CAPACITY);

  // clamps, a zero limit register behaves as one
  assign delay_lim = (max_delay == '0) ? TIME_W'(1) : max_delay;
  assign step_lim  = (max_step == '0) ? TIME_W'(1) : max_step;
  always_comb begin
    if (delay_ms == '0) begin
      delay_clamped = TIME_W'(1);
    end else if (delay_ms > delay_lim) begin
      delay_clamped = delay_lim;
    end else begin
      delay_clamped = delay_ms;
    end
  end
  assign step_clamped = (elapsed_ms > step_lim) ? step_lim : elapsed_ms;

  assign last_slot  = count - CNT_W'(1);
  assign idx_more   = (CNT_W'(idx) + CNT_W'(1)) < count;
  assign push_go    = !have_buf || out_free;
  assign scan_start = (mode == MODE_TICK) && (count != '0) && (elapsed_ms != '0);

  // a result enters the output register this cycle
  assign load_out = (in_xfer && !scan_start) ||
                    ((state == S_PUSH) && push_go && have_buf) ||
                    ((state == S_FINISH) && out_free);

  // single write port: schedule append, surviving slot update, or swap-in of the last slot
  always_comb begin
    wr = '0;
    if (in_xfer && (mode == MODE_SCHEDULE) && !full) begin
      wr.en           = 1'b1;
      wr.addr         = count[IDX_W-1:0];
      wr.data.rem     = delay_clamped;
      wr.data.payload = event_payload;
    end else if ((state == S_EVAL) && gt) begin
      wr.en           = 1'b1;
      wr.addr         = idx;
      wr.data.rem     = diff;
      wr.data.payload = rd_a.payload;
    end else if ((state == S_PUSH) && push_go) begin
      wr.en   = 1'b1;
      wr.addr = idx;
      wr.data = rd_b;
    end
  end

  dtq_slot_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (idx),
    .rd_addr_b (last_slot[IDX_W-1:0]),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  dtq_sub_unit u_sub (
    .a    (rd_a.rem),
    .b    (step),
    .diff (diff),
    .gt   (gt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      drop_cnt  <= '0;
      max_delay <= MAX_DELAY_RESET;
      max_step  <= MAX_STEP_RESET;
      out_valid <= 1'b0;
      have_buf  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          REG_MAX_DELAY: max_delay <= pwdata[TIME_W-1:0];
          REG_MAX_STEP:  max_step  <= pwdata[TIME_W-1:0];
          default:       ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (scan_start) begin
              step     <= step_clamped;
              idx      <= '0;
              have_buf <= 1'b0;
              state    <= S_READ;
            end else begin
              // one status result for any item that fires nothing
              fired         <= 1'b0;
              fired_payload <= '0;
              last          <= 1'b1;
              if ((mode == MODE_SCHEDULE) && full) begin
                drop_cnt      <= drop_cnt + 16'd1;
                dropped_count <= drop_cnt + 16'd1;
              end else begin
                dropped_count <= drop_cnt;
              end
              if ((mode == MODE_SCHEDULE) && !full) begin
                count         <= count + CNT_W'(1);
                pending_count <= count + CNT_W'(1);
              end else if (mode == MODE_CLEAR) begin
                count         <= '0;
                pending_count <= '0;
              end else begin
                pending_count <= count;
              end
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (gt) begin
            if (idx_more) begin
              idx   <= idx + IDX_W'(1);
              state <= S_READ;
            end else begin
              state <= S_FINISH;
            end
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          // slot expired: release the held event, hold this one, pull the last slot in
          if (push_go) begin
            if (have_buf) begin
              fired         <= 1'b1;
              fired_payload <= buf_payload;
              last          <= 1'b0;
              pending_count <= buf_count;
              dropped_count <= drop_cnt;
            end
            have_buf    <= 1'b1;
            buf_payload <= rd_a.payload;
            buf_count   <= last_slot;
            count       <= last_slot;
            // same index again, it now holds the moved slot
            state       <= (CNT_W'(idx) < last_slot) ? S_READ : S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            fired         <= have_buf;
            fired_payload <= have_buf ? buf_payload : '0;
            last          <= 1'b1;
            pending_count <= have_buf ? buf_count : count;
            dropped_count <= drop_cnt;
            have_buf      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/dtq_slot_store.sv
// dtq_slot_store: slot memory holding remaining time and event word per slot
// one write port, two registered read ports; depends on dtq_pkg
module dtq_slot_store
  import dtq_pkg::*;
(
  input  logic             clk,
  input  slot_wr_t         wr,
  input  logic [IDX_W-1:0] rd_addr_a,
  input  logic [IDX_W-1:0] rd_addr_b,
  output slot_t            rd_a,
  output slot_t            rd_b
);

  slot_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

endmodule

// File: rtl/core/dtq_sub_unit.sv
// dtq_sub_unit: shared subtract and compare unit used by the slot scan
// gives remaining minus step and whether the slot outlives the step; depends on dtq_pkg
module dtq_sub_unit
  import dtq_pkg::*;
(
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output logic [TIME_W-1:0] diff,
  output logic              gt
);

  logic borrow;

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign gt = !borrow && (diff != '0);

endmodule

// File: rtl/core/dtq_checker.sv
// dtq_checker: port-level assertions for delayed_event_timer_queue_core
// bound to the top level below; depends on dtq_pkg
module dtq_checker
  import dtq_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     fired,
  input logic [PAYLOAD_WIDTH-1:0] fired_payload,
  input logic                     last,
  input logic [CNT_W-1:0]         pending_count
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fired_payload) && $stable(last))
    else $error("result changed while stalled");

  // new input only when the output register can take a result
  a_in_gate: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken while output blocked");

  // status results close their item and carry no event word
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fired |-> last && (fired_payload == '0))
    else $error("malformed status result");

  // occupancy never exceeds the slot count
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending_count <= CNT_W'(CAPACITY))
    else $error("pending count beyond capacity");

  // nothing is shown right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind delayed_event_timer_queue_core dtq_checker u_dtq_checker (.*);

// File: tb/timer_queue_checker.sv
// timer_queue_checker: passive checker for delayed_event_timer_queue_core
// watches the item, result and config channels, predicts results and compares them; uses dtq_pkg
module timer_queue_checker
  import dtq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic [TIME_W-1:0]        delay_ms,
  input  logic [PAYLOAD_WIDTH-1:0] event_payload,
  input  logic [TIME_W-1:0]        elapsed_ms,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     fired,
  input  logic [PAYLOAD_WIDTH-1:0] fired_payload,
  input  logic                     last,
  input  logic [CNT_W-1:0]         pending_count,
  input  logic [15:0]              dropped_count,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]              pwdata,
  input  logic [31:0]              prdata,
  input  logic                     pready,
  output int                       mismatches,
  output int                       outstanding,
  output int                       events_fired
);

  typedef struct packed {
    logic                     fired;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic                     last;
    logic [CNT_W-1:0]         pending;
    logic [15:0]              dropped;
  } timer_result_t;

  // predicted queue contents and registers
  logic [TIME_W-1:0]        slot_rem [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] slot_pay [CAPACITY];
  int unsigned              live;
  logic [15:0]              drops;
  logic [TIME_W-1:0]        delay_cap;
  logic [TIME_W-1:0]        step_cap;

  timer_result_t due_results[$];

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // apply one accepted item to the predicted queue and queue up its results
  task automatic predict_item(input logic [1:0] m, input logic [TIME_W-1:0] d,
                              input logic [PAYLOAD_WIDTH-1:0] p, input logic [TIME_W-1:0] e);
    logic [TIME_W-1:0] lim;
    logic [TIME_W-1:0] step;
    logic [TIME_W-1:0] dly;
    int unsigned       i;
    bit                held;
    timer_result_t     r;
    held = 1'b0;
    r = '0;
    case (m)
      MODE_SCHEDULE: begin
        if (live >= CAPACITY) begin
          drops = drops + 16'd1;
        end else begin
          lim = (delay_cap == '0) ? TIME_W'(1) : delay_cap;
          dly = d;
          if (dly == '0) dly = TIME_W'(1);
          else if (dly > lim) dly = lim;
          slot_rem[IDX_W'(live)] = dly;
          slot_pay[IDX_W'(live)] = p;
          live++;
        end
      end
      MODE_TICK: begin
        if (live != 0 && e != '0) begin
          lim  = (step_cap == '0) ? TIME_W'(1) : step_cap;
          step = (e > lim) ? lim : e;
          i = 0;
          while (i < live) begin
            if (slot_rem[IDX_W'(i)] > step) begin
              slot_rem[IDX_W'(i)] = slot_rem[IDX_W'(i)] - step;
              i++;
            end else begin
              // one result held back so the final one can be marked last
              if (held) due_results.push_back(r);
              r.fired   = 1'b1;
              r.payload = slot_pay[IDX_W'(i)];
              r.last    = 1'b0;
              live--;
              slot_rem[IDX_W'(i)] = slot_rem[IDX_W'(live)];
              slot_pay[IDX_W'(i)] = slot_pay[IDX_W'(live)];
              r.pending = CNT_W'(live);
              r.dropped = drops;
              held = 1'b1;
            end
          end
        end
      end
      MODE_CLEAR: live = 0;
      default: ;
    endcase
    if (!held) begin
      r.fired   = 1'b0;
      r.payload = '0;
      r.pending = CNT_W'(live);
      r.dropped = drops;
    end
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      live         = 0;
      drops        = '0;
      delay_cap    = MAX_DELAY_RESET;
      step_cap     = MAX_STEP_RESET;
      mismatches   = 0;
      events_fired = 0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual fired=%0b payload=%0h",
                   $time, fired, fired_payload);
        end else begin
          want = due_results.pop_front();
          check_field("fired", 32'(want.fired), 32'(fired));
          check_field("fired_payload", 32'(want.payload), 32'(fired_payload));
          check_field("last", 32'(want.last), 32'(last));
          check_field("pending_count", 32'(want.pending), 32'(pending_count));
          check_field("dropped_count", 32'(want.dropped), 32'(dropped_count));
          if (want.fired) events_fired++;
        end
      end
      if (in_valid && in_ready) predict_item(mode, delay_ms, event_payload, elapsed_ms);
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[APB_ADDR_W-1:2] == REG_MAX_DELAY) delay_cap = pwdata[TIME_W-1:0];
          else step_cap = pwdata[TIME_W-1:0];
        end else if (paddr[APB_ADDR_W-1:2] == REG_MAX_DELAY) begin
          check_field("max_delay_ms readback", 32'(delay_cap), prdata);
        end else begin
          check_field("max_step_ms readback", 32'(step_cap), prdata);
        end
      end
    end
    outstanding <= due_results.size();
  end

endmodule

// File: tb/tb.sv
// tb: top of the delayed_event_timer_queue_core testbench, stimulus and verdict
// drives items, results back-pressure and config; depends on dtq_pkg and timer_queue_checker
module tb;
  import dtq_pkg::*;

  // mode three is a no-op item, not named in the package
  localparam logic [1:0] MODE_NOP = 2'd3;

  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
  localparam int SETTLE_CYCLES  = 40;    // settle time for the end of a tick scan
  localparam int HOLD_CYCLES    = 200;   // long output hold-off
  localparam int PHASE_ITEMS    = 70;    // random items per idling phase
  localparam int FULL_DROPS     = 6;     // schedules offered while the queue is full

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               mode = MODE_NOP;
  logic [TIME_W-1:0]        delay_ms = '0;
  logic [PAYLOAD_WIDTH-1:0] event_payload = '0;
  logic [TIME_W-1:0]        elapsed_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     fired;
  logic [PAYLOAD_WIDTH-1:0] fired_payload;
  logic                     last;
  logic [CNT_W-1:0]         pending_count;
  logic [15:0]              dropped_count;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]    paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  int mismatches;
  int outstanding;
  int events_fired;

  // idling knobs, hold-off request toggles and bookkeeping
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet        = 0;
  int items_sent   = 0;

  // limits as last written, used only to aim the random values
  logic [TIME_W-1:0] delay_lim = MAX_DELAY_RESET;
  logic [TIME_W-1:0] step_lim  = MAX_STEP_RESET;

  always #4 clk = ~clk;

  delayed_event_timer_queue_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .delay_ms(delay_ms), .event_payload(event_payload), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .fired(fired), .fired_payload(fired_payload), .last(last),
    .pending_count(pending_count), .dropped_count(dropped_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  timer_queue_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .delay_ms(delay_ms), .event_payload(event_payload), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .fired(fired), .fired_payload(fired_payload), .last(last),
    .pending_count(pending_count), .dropped_count(dropped_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding), .events_fired(events_fired)
  );

  // result receiver: random stalls, plus a long hold-off whenever a new request shows up
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // watchdog: any transfer on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("[delayed_event_timer_queue_core] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // offer one item and hold it until the transfer; idle cycles carry junk with valid low
  task automatic send_item(input logic [1:0] m, input logic [TIME_W-1:0] d,
                           input logic [PAYLOAD_WIDTH-1:0] p, input logic [TIME_W-1:0] e);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid      <= 1'b0;
      mode          <= 2'($urandom);
      delay_ms      <= TIME_W'($urandom);
      event_payload <= PAYLOAD_WIDTH'($urandom);
      elapsed_ms    <= TIME_W'($urandom);
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    delay_ms      <= d;
    event_payload <= p;
    elapsed_ms    <= e;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop offering until every expected result is back, then let the scan finish
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one apb access: setup, access until pready, then idle with psel low
  task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [TIME_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write both limits and read them back, only while the block is idle
  task automatic set_limits(input logic [TIME_W-1:0] dly, input logic [TIME_W-1:0] stp);
    apb_access(1'b1, REG_MAX_DELAY, dly);
    apb_access(1'b1, REG_MAX_STEP, stp);
    apb_access(1'b0, REG_MAX_DELAY, '0);
    apb_access(1'b0, REG_MAX_STEP, '0);
    delay_lim = dly;
    step_lim  = stp;
  endtask

  // delays: mostly short enough to expire soon, some at and around the clamps
  function automatic logic [TIME_W-1:0] pick_delay();
    int unsigned span;
    span = (step_lim == '0) ? 4 : 4 * int'(step_lim);
    if (span > 65535) span = 65535;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return delay_lim;
      3: return delay_lim + TIME_W'(1);
      4, 5: return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(1, span));
    endcase
  endfunction

  // elapsed time: mostly within the step clamp, with zero and oversized steps mixed in
  function automatic logic [TIME_W-1:0] pick_elapsed();
    int unsigned span;
    span = (step_lim == '0) ? 1 : int'(step_lim);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return step_lim;
      3: return step_lim + TIME_W'(1);
      4: return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(1, span));
    endcase
  endfunction

  // one random item; unused fields carry random bits; no-ops do not count
  task automatic random_item(output bit counted);
    int pick;
    pick = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 48)
      send_item(MODE_SCHEDULE, pick_delay(), PAYLOAD_WIDTH'($urandom), TIME_W'($urandom));
    else if (pick < 88)
      send_item(MODE_TICK, TIME_W'($urandom), PAYLOAD_WIDTH'($urandom), pick_elapsed());
    else if (pick < 94)
      send_item(MODE_CLEAR, TIME_W'($urandom), PAYLOAD_WIDTH'($urandom), TIME_W'($urandom));
    else begin
      send_item(MODE_NOP, TIME_W'($urandom), PAYLOAD_WIDTH'($urandom), TIME_W'($urandom));
      counted = 1'b0;
    end
  endtask

  // random stretch; optional long output hold-off and optional full pause part way in
  task automatic run_random(input int count, input int hold_at, input int pause_at);
    int useful;
    bit counted;
    useful = 0;
    while (useful < count) begin
      random_item(counted);
      if (counted) begin
        useful++;
        if (useful == hold_at) hold_reqs <= hold_reqs + 1;
        if (useful == pause_at) drain();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of the limits read back
    apb_access(1'b0, REG_MAX_DELAY, '0);
    apb_access(1'b0, REG_MAX_STEP, '0);

    // directed part at reset limits (delay 5000, step 100), receiver always ready
    send_item(MODE_TICK, '0, '0, 16'd50);                 // tick on an empty queue
    send_item(MODE_SCHEDULE, '0, '0, '0);                 // zero delay raised to 1
    send_item(MODE_SCHEDULE, '1, '1, '1);                 // delay clamped to the limit
    send_item(MODE_TICK, '1, '1, '0);                     // zero elapsed, nothing moves
    send_item(MODE_TICK, '0, '0, '1);                     // step clamped, first slot fires
    send_item(MODE_NOP, '1, '1, '1);                      // no-op
    // fill to capacity with a mix that exercises the swap-with-last order
    send_item(MODE_SCHEDULE, 16'd1,   32'hA000_0001, '0);
    send_item(MODE_SCHEDULE, 16'd300, 32'hA000_0002, '0);
    send_item(MODE_SCHEDULE, 16'd2,   32'hA000_0003, '0);
    send_item(MODE_SCHEDULE, 16'd1,   32'hA000_0004, '0);
    send_item(MODE_SCHEDULE, 16'd50,  32'hA000_0005, '0);
    send_item(MODE_SCHEDULE, 16'd3,   32'hA000_0006, '0);
    send_item(MODE_SCHEDULE, 16'd1,   32'hA000_0007, '0);
    // schedule while full: dropped and counted
    send_item(MODE_SCHEDULE, 16'd10, 32'h5555_5555, '0);
    send_item(MODE_SCHEDULE, 16'd20, 32'hAAAA_AAAA, '0);
    send_item(MODE_TICK, '0, '0, 16'd100);                // several expire in one scan
    send_item(MODE_CLEAR, '0, '0, '0);                    // clear keeps the drop count
    send_item(MODE_SCHEDULE, 16'd7, 32'h0BAD_F00D, '0);
    send_item(MODE_CLEAR, '1, '1, '1);
    send_item(MODE_TICK, '0, '0, 16'd5);                  // tick after clear
    drain();

    // both limits zero behave as one
    set_limits('0, '0);
    send_item(MODE_SCHEDULE, '1, 32'h1234_5678, '0);
    send_item(MODE_TICK, '0, '0, '1);
    drain();

    // both limits at the top of their range
    set_limits('1, '1);
    send_item(MODE_SCHEDULE, '1, 32'h8765_4321, '0);
    send_item(MODE_SCHEDULE, 16'd1, 32'hFFFF_0000, '0);
    send_item(MODE_TICK, '0, '0, '1);
    drain();

    // phase one: sender idles a quarter, receiver nearly half, plus a long hold-off
    set_limits(16'd250, 16'd60);
    in_idle_pct  = 25;
    out_idle_pct <= 47;
    run_random(PHASE_ITEMS, 30, 0);
    drain();

    // phase two: idling swapped; every delay clamps to one; a full pause part way in
    set_limits(16'd1, '1);
    in_idle_pct  = 47;
    out_idle_pct <= 25;
    run_random(PHASE_ITEMS, 0, 45);
    drain();

    // phase three: no idling; long delays allowed, step limit zero
    set_limits('1, '0);
    in_idle_pct  = 0;
    out_idle_pct <= 0;
    run_random(PHASE_ITEMS, 0, 0);

    // fill the queue, then offer schedules that must be dropped and counted
    send_item(MODE_CLEAR, '0, '0, '0);
    repeat (CAPACITY) send_item(MODE_SCHEDULE, '1, PAYLOAD_WIDTH'($urandom), '0);
    repeat (FULL_DROPS)
      send_item(MODE_SCHEDULE, TIME_W'($urandom), PAYLOAD_WIDTH'($urandom), TIME_W'($urandom));
    send_item(MODE_CLEAR, '0, '0, '0);
    drain();

    $display("run: %0d items over six limit settings, %0d events fired, %0d mismatches",
             items_sent, events_fired, mismatches);
    $display("run: included a long output hold-off, a full pause and drops while full");
    if (mismatches == 0) begin
      $display("[delayed_event_timer_queue_core] OK");
    end else begin
      $display("[delayed_event_timer_queue_core] ERROR");
    end
    $finish;
  end

endmodule
